FILE: src/sseq_pkg.sv
// ----------------------------------------------------------------------------
// Step sequencer package
// Shared constants, request types and controller states for the step
// sequencer with slide.
// ----------------------------------------------------------------------------
package sseq_pkg;

  localparam int unsigned NUM_STEPS = 32;
  localparam int unsigned NUM_NOTES = 128;
  localparam int unsigned STEP_W    = $clog2(NUM_STEPS);
  localparam int unsigned NOTE_W    = 7;
  localparam int unsigned VEL_W     = 7;
  localparam int unsigned IDX_W     = 5;
  localparam int unsigned ROW_BITS  = 8;
  localparam int unsigned BIT_W     = $clog2(ROW_BITS);
  localparam int unsigned NUM_ROWS  = NUM_NOTES / ROW_BITS;
  localparam int unsigned ROW_W     = $clog2(NUM_ROWS);
  localparam int unsigned CNT_W     = $clog2(NUM_NOTES + 1);
  localparam int unsigned FPS_W     = 32;

  localparam logic [FPS_W-1:0] ONE_FRAME    = 32'd256;
  localparam logic [FPS_W-1:0] RESET_FPS    = 32'd1440000;
  localparam logic [VEL_W-1:0] OFF_VELOCITY = 7'd100;

  typedef enum logic {
    CMD_TICK  = 1'b0,
    CMD_WRITE = 1'b1
  } cmd_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_ENTRY,
    ST_ROW_RD,
    ST_ROW_LOAD,
    ST_ROW_OFF,
    ST_ON_RD,
    ST_ON_WR
  } state_e;

  typedef struct packed {
    logic              cmd;
    logic [IDX_W-1:0]  step_index;
    logic              step_on;
    logic [NOTE_W-1:0] step_note;
    logic              step_slide;
    logic [VEL_W-1:0]  step_velocity;
  } in_req_t;

  typedef struct packed {
    logic              is_note_on;
    logic [NOTE_W-1:0] note;
    logic [VEL_W-1:0]  velocity;
    logic              last;
  } out_req_t;

  typedef struct packed {
    logic              on;
    logic [NOTE_W-1:0] note;
    logic              slide;
    logic [VEL_W-1:0]  velocity;
  } step_entry_t;

endpackage

FILE: src/step_sequencer_with_slide.sv
// ----------------------------------------------------------------------------
// Step sequencer with slide
// A step table memory and a sounding-note bitmap memory, driven by one
// read-modify-write controller that emits note-off and note-on events.
// ----------------------------------------------------------------------------
//  Channel | Direction | Handshake           | Payload
//  in      | input     | in_valid_i/in_stall_o   | in_req_i (tick or step write)
//  out     | output    | out_valid_o/out_stall_i | out_req_o (one note event)
//  cfg     | input     | cfg_valid_i/cfg_ready_o | cfg_data_i (Q24.8 frames)
//
// A write, or a tick with no step due, is taken in idle and leaves it idle.
// A fired step reads its entry, then goes to release or note-on. A release
// reads, loads and scans each bitmap row while notes still sound, and a
// note-on reads and writes its row. Output stalls hold both event states.
// Reset clears the step table and bitmap through per-entry and per-row valid
// bits, so no clearing pass is needed.
// ----------------------------------------------------------------------------
module step_sequencer_with_slide (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_stall_o,
  input  sseq_pkg::in_req_t in_req_i,
  output logic              out_valid_o,
  input  logic              out_stall_i,
  output sseq_pkg::out_req_t out_req_o,
  input  logic              cfg_valid_i,
  output logic              cfg_ready_o,
  input  logic [31:0]       cfg_data_i
);
  import sseq_pkg::*;

  state_e            state_q, state_d;
  logic [FPS_W-1:0]  fps_q;
  logic [FPS_W-1:0]  fps_eff;
  logic [FPS_W-1:0]  cd_q, cd_d;
  logic [STEP_W-1:0] cur_q, cur_d;
  logic [STEP_W-1:0] step_next;
  logic [CNT_W-1:0]  cnt_q, cnt_d;
  logic [ROW_W-1:0]  row_q, row_d;
  logic [ROW_BITS-1:0] bits_q, bits_d;
  logic [ROW_BITS-1:0] bits_clr;
  logic [BIT_W-1:0]  low_idx;
  logic              e_on_q, e_on_d;
  logic [NOTE_W-1:0] e_note_q, e_note_d;
  logic [VEL_W-1:0]  e_vel_q, e_vel_d;

  step_entry_t       step_mem [NUM_STEPS];
  logic [NUM_STEPS-1:0] step_vld_q;
  step_entry_t       step_rd_q, prev_rd_q;
  logic              step_rd_vld_q, prev_rd_vld_q;
  logic              step_rd_en, step_wr_en;
  logic [STEP_W-1:0] step_wr_addr;
  step_entry_t       step_wr_data;
  step_entry_t       entry, prev_entry;

  logic [ROW_BITS-1:0] map_mem [NUM_ROWS];
  logic [NUM_ROWS-1:0] map_vld_q;
  logic [ROW_BITS-1:0] map_rd_q;
  logic                map_rd_vld_q;
  logic                map_rd_en, map_wr_en;
  logic [ROW_W-1:0]    map_rd_addr, map_wr_addr;
  logic [ROW_BITS-1:0] map_wr_data;
  logic [ROW_BITS-1:0] on_row;
  logic [ROW_BITS-1:0] on_mask;

  logic              out_valid_q, out_valid_d;
  out_req_t          out_q, out_d;
  logic              out_free;
  logic              accept;
  logic              due;
  logic              rel;

  assign in_stall_o  = (state_q != ST_IDLE);
  assign accept      = in_valid_i && !in_stall_o;
  assign cfg_ready_o = 1'b1;
  assign out_valid_o = out_valid_q;
  assign out_req_o   = out_q;
  assign out_free    = !out_valid_q || !out_stall_i;

  assign fps_eff   = (fps_q < ONE_FRAME) ? ONE_FRAME : fps_q;
  assign due       = (cd_q < ONE_FRAME);
  assign step_next = (cur_q == STEP_W'(NUM_STEPS - 1)) ? '0 : cur_q + 1'b1;

  assign step_wr_addr = STEP_W'(in_req_i.step_index);
  assign step_wr_data = '{on:       in_req_i.step_on,
                          note:     in_req_i.step_note,
                          slide:    in_req_i.step_slide,
                          velocity: in_req_i.step_velocity};

  assign entry      = step_rd_vld_q ? step_rd_q : '0;
  assign prev_entry = prev_rd_vld_q ? prev_rd_q : '0;
  assign rel        = !entry.on || (cur_q == '0) || !prev_entry.slide;

  assign on_row   = map_rd_vld_q ? map_rd_q : '0;
  assign on_mask  = ROW_BITS'(1) << e_note_q[BIT_W-1:0];
  assign bits_clr = bits_q & (bits_q - 1'b1);

  always_comb begin
    low_idx = '0;
    for (int i = ROW_BITS - 1; i >= 0; i--) begin
      if (bits_q[i]) begin
        low_idx = BIT_W'(i);
      end
    end
  end

  always_comb begin
    state_d     = state_q;
    cd_d        = cd_q;
    cur_d       = cur_q;
    cnt_d       = cnt_q;
    row_d       = row_q;
    bits_d      = bits_q;
    e_on_d      = e_on_q;
    e_note_d    = e_note_q;
    e_vel_d     = e_vel_q;
    step_rd_en  = 1'b0;
    step_wr_en  = 1'b0;
    map_rd_en   = 1'b0;
    map_rd_addr = row_q;
    map_wr_en   = 1'b0;
    map_wr_addr = row_q;
    map_wr_data = '0;
    out_valid_d = out_valid_q && out_stall_i;
    out_d       = out_q;
    case (state_q)
      ST_IDLE: begin
        if (accept) begin
          if (in_req_i.cmd == CMD_WRITE) begin
            step_wr_en = ({1'b0, FPS_W'(in_req_i.step_index)} <
                          (FPS_W + 1)'(NUM_STEPS));
          end else if (due) begin
            cd_d       = FPS_W'({1'b0, cd_q} + {1'b0, fps_eff} - {1'b0, ONE_FRAME});
            cur_d      = step_next;
            step_rd_en = 1'b1;
            state_d    = ST_ENTRY;
          end else begin
            cd_d = cd_q - ONE_FRAME;
          end
        end
      end
      ST_ENTRY: begin
        e_on_d   = entry.on;
        e_note_d = entry.note;
        e_vel_d  = entry.velocity;
        row_d    = '0;
        state_d  = rel ? ST_ROW_RD : ST_ON_RD;
      end
      ST_ROW_RD: begin
        if (cnt_q == '0) begin
          state_d = e_on_q ? ST_ON_RD : ST_IDLE;
        end else begin
          map_rd_en = 1'b1;
          state_d   = ST_ROW_LOAD;
        end
      end
      ST_ROW_LOAD: begin
        bits_d  = map_rd_vld_q ? map_rd_q : '0;
        state_d = ST_ROW_OFF;
      end
      ST_ROW_OFF: begin
        if (bits_q == '0) begin
          map_wr_en = 1'b1;
          row_d     = row_q + 1'b1;
          state_d   = ST_ROW_RD;
        end else if (out_free) begin
          out_valid_d      = 1'b1;
          out_d.is_note_on = 1'b0;
          out_d.note       = NOTE_W'({row_q, low_idx});
          out_d.velocity   = OFF_VELOCITY;
          out_d.last       = (cnt_q == CNT_W'(1)) && !e_on_q;
          bits_d           = bits_clr;
          cnt_d            = cnt_q - 1'b1;
        end
      end
      ST_ON_RD: begin
        map_rd_en   = 1'b1;
        map_rd_addr = e_note_q[NOTE_W-1:BIT_W];
        state_d     = ST_ON_WR;
      end
      ST_ON_WR: begin
        if (out_free) begin
          map_wr_en        = 1'b1;
          map_wr_addr      = e_note_q[NOTE_W-1:BIT_W];
          map_wr_data      = on_row | on_mask;
          cnt_d            = cnt_q + CNT_W'((on_row & on_mask) == '0);
          out_valid_d      = 1'b1;
          out_d.is_note_on = 1'b1;
          out_d.note       = e_note_q;
          out_d.velocity   = e_vel_q;
          out_d.last       = 1'b1;
          state_d          = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      fps_q       <= RESET_FPS;
      cd_q        <= '0;
      cur_q       <= STEP_W'(NUM_STEPS - 1);
      cnt_q       <= '0;
      row_q       <= '0;
      out_valid_q <= 1'b0;
      step_vld_q  <= '0;
      map_vld_q   <= '0;
    end else begin
      state_q     <= state_d;
      cd_q        <= cd_d;
      cur_q       <= cur_d;
      cnt_q       <= cnt_d;
      row_q       <= row_d;
      out_valid_q <= out_valid_d;
      if (cfg_valid_i && cfg_ready_o) begin
        fps_q <= cfg_data_i;
      end
      if (step_wr_en) begin
        step_vld_q[step_wr_addr] <= 1'b1;
      end
      if (map_wr_en) begin
        map_vld_q[map_wr_addr] <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    bits_q   <= bits_d;
    e_on_q   <= e_on_d;
    e_note_q <= e_note_d;
    e_vel_q  <= e_vel_d;
    out_q    <= out_d;
  end

  always_ff @(posedge clk_i) begin
    if (step_wr_en) begin
      step_mem[step_wr_addr] <= step_wr_data;
    end
    if (step_rd_en) begin
      step_rd_q     <= step_mem[step_next];
      prev_rd_q     <= step_mem[cur_q];
      step_rd_vld_q <= step_vld_q[step_next];
      prev_rd_vld_q <= step_vld_q[cur_q];
    end
  end

  always_ff @(posedge clk_i) begin
    if (map_wr_en) begin
      map_mem[map_wr_addr] <= map_wr_data;
    end
    if (map_rd_en) begin
      map_rd_q     <= map_mem[map_rd_addr];
      map_rd_vld_q <= map_vld_q[map_rd_addr];
    end
  end

`ifndef NO_ASSERTIONS
  a_cnt_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= CNT_W'(NUM_NOTES))
    else $error("sounding count exceeds note range");

  a_off_has_note: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_ROW_OFF) && (bits_q != '0) |-> (cnt_q != '0))
    else $error("note-off pending with no sounding note counted");

  a_due_fires: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept && (in_req_i.cmd == CMD_TICK) && due |=> (state_q == ST_ENTRY))
    else $error("due tick did not start a step");

  a_on_is_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_req_o.is_note_on |-> out_req_o.last)
    else $error("note-on event not flagged last");

  a_step_advance: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_IDLE) && !(accept && (in_req_i.cmd == CMD_TICK) && due)
      |=> $stable(cur_q))
    else $error("current step moved without a fired step");
`endif

endmodule
